// ===== src/dssl_pkg.sv =====
// Shared types and constants for the dual servo slew limiter.
// Used by dssl_chan and dual_servo_slew_limiter; depends on nothing.
package dssl_pkg;

    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned PULSE_W     = 12;
    localparam int unsigned DZ_W        = 6;
    localparam int unsigned SPEED_W     = 8;
    localparam int unsigned STEER_W     = 11;
    localparam int unsigned SPEED_LIM_W = 7;
    localparam int unsigned STEER_LIM_W = 10;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned REG_IDX_W   = 3;

    localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4095;

    // Register reset values
    localparam logic [SPEED_LIM_W-1:0] RST_SPEED_LIMIT = 7'd80;
    localparam logic [STEER_LIM_W-1:0] RST_STEER_LIMIT = 10'd400;
    localparam logic [DZ_W-1:0]        RST_SPEED_DZ    = 6'd10;
    localparam logic [DZ_W-1:0]        RST_STEER_DZ    = 6'd10;
    localparam logic [SPEED_LIM_W-1:0] RST_SPEED_STEP  = 7'd10;
    localparam logic [STEER_LIM_W-1:0] RST_STEER_STEP  = 10'd300;
    localparam logic [PULSE_W-1:0]     RST_NEUTRAL     = 12'd1500;

    // Register map, word index
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEER_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_DZ    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEER_DZ    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_STEP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEER_STEP  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_NEUTRAL     = 3'd6;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_SPEED = 2'd1,
        CMD_SET_STEER = 2'd2,
        CMD_ESTOP     = 2'd3
    } t_cmd;

    // Per-channel decoded command
    typedef struct packed {
        logic tick;
        logic set;
        logic estop;
    } t_chan_ctl;

endpackage

// ===== src/dual_servo_slew_limiter.sv =====
// Dual servo slew limiter top level: APB registers, input word register,
// channel state and result register. Depends on dssl_pkg and dssl_chan.
//
// Takes one command word per clock while o_in_ready is high and returns one result word for each.
// The word is held in an input register, then both channels are computed in
// a single combinational pass into the channel state, which is also the
// result register; that register loads once the result slot is free, so a
// downstream stall holds the word in the input register meanwhile. The input
// register keeps accepting while a result waits, so a stall downstream
// costs at most one buffered word before o_in_ready drops. Configuration
// writes are meant for idle periods; a new neutral value shows only at the
// next servo write.
module dual_servo_slew_limiter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dssl_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [dssl_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [dssl_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_command,
    input  logic signed [dssl_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [dssl_pkg::PULSE_W-1:0]          o_speed_pulse,
    output logic [dssl_pkg::PULSE_W-1:0]          o_steer_pulse,
    output logic                                  o_speed_written,
    output logic                                  o_steer_written,
    output logic signed [dssl_pkg::SPEED_W-1:0]   o_present_speed,
    output logic signed [dssl_pkg::STEER_W-1:0]   o_present_steer
);

    // Configuration registers
    logic [dssl_pkg::SPEED_LIM_W-1:0] r_speed_limit;
    logic [dssl_pkg::STEER_LIM_W-1:0] r_steer_limit;
    logic [dssl_pkg::DZ_W-1:0]        r_speed_dz;
    logic [dssl_pkg::DZ_W-1:0]        r_steer_dz;
    logic [dssl_pkg::SPEED_LIM_W-1:0] r_speed_step;
    logic [dssl_pkg::STEER_LIM_W-1:0] r_steer_step;
    logic [dssl_pkg::PULSE_W-1:0]     r_neutral;

    logic                             w_cfg_wr;
    logic [dssl_pkg::REG_IDX_W-1:0]   w_cfg_idx;

    // Pipeline
    logic                                 r_in_valid;
    dssl_pkg::t_cmd                       r_in_cmd;
    logic signed [dssl_pkg::VALUE_W-1:0]  r_in_value;
    logic                                 r_out_valid;
    logic                                 w_move;

    // Channel state (doubles as result register)
    logic signed [dssl_pkg::SPEED_W-1:0]  r_speed_target;
    logic signed [dssl_pkg::STEER_W-1:0]  r_steer_target;
    logic signed [dssl_pkg::SPEED_W-1:0]  r_speed_now;
    logic signed [dssl_pkg::STEER_W-1:0]  r_steer_now;
    logic [dssl_pkg::PULSE_W-1:0]         r_speed_pulse;
    logic [dssl_pkg::PULSE_W-1:0]         r_steer_pulse;
    logic                                 r_speed_written;
    logic                                 r_steer_written;

    dssl_pkg::t_chan_ctl                  w_speed_ctl;
    dssl_pkg::t_chan_ctl                  w_steer_ctl;
    logic signed [dssl_pkg::SPEED_W-1:0]  n_speed_target;
    logic signed [dssl_pkg::STEER_W-1:0]  n_steer_target;
    logic signed [dssl_pkg::SPEED_W-1:0]  n_speed_now;
    logic signed [dssl_pkg::STEER_W-1:0]  n_steer_now;
    logic [dssl_pkg::PULSE_W-1:0]         n_speed_pulse;
    logic [dssl_pkg::PULSE_W-1:0]         n_steer_pulse;
    logic                                 n_speed_written;
    logic                                 n_steer_written;

    // APB
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[dssl_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= dssl_pkg::RST_SPEED_LIMIT;
            r_steer_limit <= dssl_pkg::RST_STEER_LIMIT;
            r_speed_dz    <= dssl_pkg::RST_SPEED_DZ;
            r_steer_dz    <= dssl_pkg::RST_STEER_DZ;
            r_speed_step  <= dssl_pkg::RST_SPEED_STEP;
            r_steer_step  <= dssl_pkg::RST_STEER_STEP;
            r_neutral     <= dssl_pkg::RST_NEUTRAL;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                dssl_pkg::REG_SPEED_LIMIT: begin
                    r_speed_limit <= pwdata[dssl_pkg::SPEED_LIM_W-1:0];
                end
                dssl_pkg::REG_STEER_LIMIT: begin
                    r_steer_limit <= pwdata[dssl_pkg::STEER_LIM_W-1:0];
                end
                dssl_pkg::REG_SPEED_DZ: begin
                    r_speed_dz <= pwdata[dssl_pkg::DZ_W-1:0];
                end
                dssl_pkg::REG_STEER_DZ: begin
                    r_steer_dz <= pwdata[dssl_pkg::DZ_W-1:0];
                end
                dssl_pkg::REG_SPEED_STEP: begin
                    r_speed_step <= pwdata[dssl_pkg::SPEED_LIM_W-1:0];
                end
                dssl_pkg::REG_STEER_STEP: begin
                    r_steer_step <= pwdata[dssl_pkg::STEER_LIM_W-1:0];
                end
                dssl_pkg::REG_NEUTRAL: begin
                    r_neutral <= pwdata[dssl_pkg::PULSE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            dssl_pkg::REG_SPEED_LIMIT: prdata = 32'(r_speed_limit);
            dssl_pkg::REG_STEER_LIMIT: prdata = 32'(r_steer_limit);
            dssl_pkg::REG_SPEED_DZ:    prdata = 32'(r_speed_dz);
            dssl_pkg::REG_STEER_DZ:    prdata = 32'(r_steer_dz);
            dssl_pkg::REG_SPEED_STEP:  prdata = 32'(r_speed_step);
            dssl_pkg::REG_STEER_STEP:  prdata = 32'(r_steer_step);
            dssl_pkg::REG_NEUTRAL:     prdata = 32'(r_neutral);
            default:                   prdata = '0;
        endcase
    end

    // Handshake: advance the buffered word when the result slot is free
    assign w_move     = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd   <= dssl_pkg::t_cmd'(i_command);
            r_in_value <= i_value;
        end
    end

    // Command decode
    always_comb begin
        w_speed_ctl.tick  = (r_in_cmd == dssl_pkg::CMD_TICK);
        w_speed_ctl.set   = (r_in_cmd == dssl_pkg::CMD_SET_SPEED);
        w_speed_ctl.estop = (r_in_cmd == dssl_pkg::CMD_ESTOP);
        w_steer_ctl.tick  = (r_in_cmd == dssl_pkg::CMD_TICK);
        w_steer_ctl.set   = (r_in_cmd == dssl_pkg::CMD_SET_STEER);
        w_steer_ctl.estop = (r_in_cmd == dssl_pkg::CMD_ESTOP);
    end

    dssl_chan #(
        .NW  (dssl_pkg::SPEED_W),
        .LW  (dssl_pkg::SPEED_LIM_W),
        .NEG (1'b0)
    ) u_speed (
        .i_ctl       (w_speed_ctl),
        .i_value     (r_in_value),
        .i_target    (r_speed_target),
        .i_now       (r_speed_now),
        .i_limit     (r_speed_limit),
        .i_step      (r_speed_step),
        .i_dead_zone (r_speed_dz),
        .i_mid       (r_neutral),
        .o_target    (n_speed_target),
        .o_now       (n_speed_now),
        .o_pulse     (n_speed_pulse),
        .o_written   (n_speed_written)
    );

    dssl_chan #(
        .NW  (dssl_pkg::STEER_W),
        .LW  (dssl_pkg::STEER_LIM_W),
        .NEG (1'b1)
    ) u_steer (
        .i_ctl       (w_steer_ctl),
        .i_value     (r_in_value),
        .i_target    (r_steer_target),
        .i_now       (r_steer_now),
        .i_limit     (r_steer_limit),
        .i_step      (r_steer_step),
        .i_dead_zone (r_steer_dz),
        .i_mid       (r_neutral),
        .o_target    (n_steer_target),
        .o_now       (n_steer_now),
        .o_pulse     (n_steer_pulse),
        .o_written   (n_steer_written)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_target  <= '0;
            r_steer_target  <= '0;
            r_speed_now     <= '0;
            r_steer_now     <= '0;
            r_speed_pulse   <= dssl_pkg::RST_NEUTRAL;
            r_steer_pulse   <= dssl_pkg::RST_NEUTRAL;
            r_speed_written <= 1'b0;
            r_steer_written <= 1'b0;
        end else if (w_move) begin
            r_speed_target  <= n_speed_target;
            r_steer_target  <= n_steer_target;
            r_speed_now     <= n_speed_now;
            r_steer_now     <= n_steer_now;
            r_speed_written <= n_speed_written;
            r_steer_written <= n_steer_written;
            if (n_speed_written) begin
                r_speed_pulse <= n_speed_pulse;
            end
            if (n_steer_written) begin
                r_steer_pulse <= n_steer_pulse;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed_pulse   = r_speed_pulse;
    assign o_steer_pulse   = r_steer_pulse;
    assign o_speed_written = r_speed_written;
    assign o_steer_written = r_steer_written;
    assign o_present_speed = r_speed_now;
    assign o_present_steer = r_steer_now;

    // Emergency stop zeroes both channels and writes both servos
    a_estop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in_cmd == dssl_pkg::CMD_ESTOP) |=>
        (o_out_valid && o_speed_written && o_steer_written &&
         o_present_speed == '0 && o_present_steer == '0))
        else $error("estop did not clear and write both channels");

    // Target updates never write a servo
    a_set_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (r_in_cmd == dssl_pkg::CMD_SET_SPEED ||
                    r_in_cmd == dssl_pkg::CMD_SET_STEER)) |=>
        (!o_speed_written && !o_steer_written))
        else $error("set command wrote a servo");

    // A channel not written keeps its present value and pulse
    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (o_speed_written ||
                    (o_present_speed == $past(r_speed_now) &&
                     o_speed_pulse == $past(r_speed_pulse))))
        else $error("speed changed without a servo write");

    a_steer_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (o_steer_written ||
                    (o_present_steer == $past(r_steer_now) &&
                     o_steer_pulse == $past(r_steer_pulse))))
        else $error("steer changed without a servo write");

endmodule

// ===== src/dssl_chan.sv =====
// One servo channel: target clamp, ramp step, magnitude clamp, dead zone
// and pulse saturation. Pure combinational. Depends on dssl_pkg.
module dssl_chan #(
    parameter int unsigned NW  = dssl_pkg::SPEED_W,
    parameter int unsigned LW  = dssl_pkg::SPEED_LIM_W,
    parameter bit          NEG = 1'b0
) (
    input  dssl_pkg::t_chan_ctl                 i_ctl,
    input  logic signed [dssl_pkg::VALUE_W-1:0] i_value,
    input  logic signed [NW-1:0]                i_target,
    input  logic signed [NW-1:0]                i_now,
    input  logic [LW-1:0]                       i_limit,
    input  logic [LW-1:0]                       i_step,
    input  logic [dssl_pkg::DZ_W-1:0]           i_dead_zone,
    input  logic [dssl_pkg::PULSE_W-1:0]        i_mid,
    output logic signed [NW-1:0]                o_target,
    output logic signed [NW-1:0]                o_now,
    output logic [dssl_pkg::PULSE_W-1:0]        o_pulse,
    output logic                                o_written
);

    localparam int unsigned VW = dssl_pkg::VALUE_W + 1;
    localparam int unsigned WW = NW + 2;
    localparam int unsigned PW = (NW + 3 > 14) ? NW + 3 : 14;

    logic signed [VW-1:0] val_v;
    logic signed [VW-1:0] lim_v;
    logic signed [VW-1:0] tclamp_v;
    logic signed [WW-1:0] now_w;
    logic signed [WW-1:0] tgt_w;
    logic signed [WW-1:0] step_w;
    logic signed [WW-1:0] lim_w;
    logic signed [WW-1:0] up_w;
    logic signed [WW-1:0] dn_w;
    logic signed [WW-1:0] nxt_w;
    logic signed [WW-1:0] c_w;
    logic                 moved;
    logic signed [PW-1:0] c_p;
    logic signed [PW-1:0] dz_p;
    logic signed [PW-1:0] off_p;
    logic signed [PW-1:0] mid_p;
    logic signed [PW-1:0] sum_p;

    // Clamp the requested target to the limit
    always_comb begin
        val_v = {i_value[dssl_pkg::VALUE_W-1], i_value};
        lim_v = {{(VW-LW){1'b0}}, i_limit};
        if (val_v > lim_v) begin
            tclamp_v = lim_v;
        end else if (val_v < -lim_v) begin
            tclamp_v = -lim_v;
        end else begin
            tclamp_v = val_v;
        end
    end

    // Ramp toward target (or go to zero on estop), then clamp to the present limit
    always_comb begin
        now_w  = {{(WW-NW){i_now[NW-1]}}, i_now};
        tgt_w  = {{(WW-NW){i_target[NW-1]}}, i_target};
        step_w = {{(WW-LW){1'b0}}, i_step};
        lim_w  = {{(WW-LW){1'b0}}, i_limit};
        up_w   = now_w + step_w;
        dn_w   = now_w - step_w;
        moved  = 1'b1;
        if (tgt_w > now_w) begin
            nxt_w = (up_w < tgt_w) ? up_w : tgt_w;
        end else if (tgt_w < now_w) begin
            nxt_w = (dn_w > tgt_w) ? dn_w : tgt_w;
        end else begin
            nxt_w = now_w;
            moved = 1'b0;
        end
        if (i_ctl.estop) begin
            nxt_w = '0;
        end
        if (nxt_w > lim_w) begin
            c_w = lim_w;
        end else if (nxt_w < -lim_w) begin
            c_w = -lim_w;
        end else begin
            c_w = nxt_w;
        end
    end

    // Dead zone away from zero, offset from mid, saturate
    always_comb begin
        c_p   = {{(PW-WW){c_w[WW-1]}}, c_w};
        dz_p  = {{(PW-dssl_pkg::DZ_W){1'b0}}, i_dead_zone};
        mid_p = {{(PW-dssl_pkg::PULSE_W){1'b0}}, i_mid};
        if (c_p > 0) begin
            off_p = c_p + dz_p;
        end else if (c_p < 0) begin
            off_p = c_p - dz_p;
        end else begin
            off_p = '0;
        end
        sum_p = NEG ? (mid_p - off_p) : (mid_p + off_p);
        if (sum_p < 0) begin
            o_pulse = '0;
        end else if (sum_p > $signed({{(PW-dssl_pkg::PULSE_W){1'b0}}, dssl_pkg::PULSE_MAX}))
        begin
            o_pulse = dssl_pkg::PULSE_MAX;
        end else begin
            o_pulse = sum_p[dssl_pkg::PULSE_W-1:0];
        end
    end

    assign o_written = i_ctl.estop | (i_ctl.tick & moved);
    assign o_now     = o_written ? c_w[NW-1:0] : i_now;

    always_comb begin
        if (i_ctl.estop) begin
            o_target = '0;
        end else if (i_ctl.set) begin
            o_target = tclamp_v[NW-1:0];
        end else begin
            o_target = i_target;
        end
    end

endmodule
